>>> rtl/core/nssu_pkg.sv
// shared types and constants for the nfa state set stepper
// no dependencies; imported by every module of the block
`default_nettype none

package nssu_pkg;

    // fixed field widths of the stream words
    localparam int MASK_W   = 16;
    localparam int STATE_W  = 4;
    localparam int SYMBOL_W = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // default automaton size
    localparam int NUM_STATES_DEF  = 16;
    localparam int NUM_SYMBOLS_DEF = 4;

    // input word layout in s_tdata
    localparam int S_DATA_W = 24;
    localparam int S_FROM_LSB = 0;
    localparam int S_SYM_LSB  = S_FROM_LSB + STATE_W;
    localparam int S_NEXT_LSB = S_SYM_LSB + SYMBOL_W;
    localparam int S_WS_BIT   = S_NEXT_LSB + MASK_W;

    // result word layout in m_tdata
    localparam int M_DATA_W = 24;
    localparam int M_ACC_BIT  = MASK_W;
    localparam int M_DEAD_BIT = MASK_W + 1;

    // item kinds carried on s_tuser
    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_MASK = 1'b0,
        CFG_FINAL_MASK   = 1'b1
    } cfg_idx_t;

    // table row write command
    typedef struct packed {
        logic                en;
        logic [STATE_W-1:0]  from_state;
        logic [SYMBOL_W-1:0] symbol;
        logic [MASK_W-1:0]   mask;
    } tbl_wr_t;

endpackage

`default_nettype wire

>>> rtl/core/nfa_state_set_stepper_unit.sv
// top level of the nfa state set stepper: input register, active set, table, result register
// depends on nssu_pkg, nssu_table and nssu_out_stage
`default_nettype none

// Bit-parallel NFA stepper. Each input word is either a table load (s_tuser = 0), which
// writes the next-state mask for one (state, symbol) pair, or a step (s_tuser = 1), which
// replaces the active set by the OR of the table rows of every active state for the symbol;
// with word_start set the step starts from initial_mask instead. Every word yields one result
// word with the active set, an accepted flag (set meets final_mask) and a dead flag (set
// empty). Throughput is one word per clock unless m_tready stalls the result register: a
// word is held in the input register while the row selection and OR run, and the result
// and the new active set are registered together, so the following word sees the updated
// set without any bubble. The table is reset to all zero by aresetn; no clearing pass is
// needed. Configuration writes take effect at once and are meant for idle periods.
module nfa_state_set_stepper_unit
    import nssu_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    // input words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata: from_state[3:0], symbol[5:4], next_states[21:6], word_start[22], zero[23]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // s_tuser: kind[0]
    input  wire logic                 s_tuser,
    // result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata: active_states[15:0], accepted[16], dead[17], zero[23:18]
    output logic      [M_DATA_W-1:0]  m_tdata
);

    localparam int STATES_EFF = (NUM_STATES < MASK_W) ? NUM_STATES : MASK_W;
    localparam logic [MASK_W-1:0] STATE_MASK = {MASK_W{1'b1}} >> (MASK_W - STATES_EFF);

    // configuration registers
    logic [MASK_W-1:0] initial_mask_reg;
    logic [MASK_W-1:0] final_mask_reg;

    // input register
    logic                in_valid_reg;
    logic                in_valid_next;
    kind_t               kind_reg;
    logic [STATE_W-1:0]  from_state_reg;
    logic [SYMBOL_W-1:0] symbol_reg;
    logic [MASK_W-1:0]   next_states_reg;
    logic                word_start_reg;

    // active set
    logic [MASK_W-1:0]   active_set_reg;
    logic [MASK_W-1:0]   active_set_next;

    logic                out_can_load;
    logic                advance;
    logic                s_fire;
    logic [MASK_W-1:0]   src_mask;
    logic [MASK_W-1:0]   step_mask;
    tbl_wr_t             tbl_wr;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_mask_reg <= MASK_W'(1);
            final_mask_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_INITIAL_MASK: initial_mask_reg <= cfg_wr_data;
                CFG_FINAL_MASK:   final_mask_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // handshake: the held word moves on when the result register is free
    assign advance  = in_valid_reg && out_can_load;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // input payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg        <= kind_t'(s_tuser);
            from_state_reg  <= s_tdata[S_FROM_LSB +: STATE_W];
            symbol_reg      <= s_tdata[S_SYM_LSB +: SYMBOL_W];
            next_states_reg <= s_tdata[S_NEXT_LSB +: MASK_W];
            word_start_reg  <= s_tdata[S_WS_BIT];
        end
    end

    // step source and table access
    assign src_mask = word_start_reg ? (initial_mask_reg & STATE_MASK) : active_set_reg;

    always_comb begin
        tbl_wr.en         = advance && (kind_reg == KIND_LOAD);
        tbl_wr.from_state = from_state_reg;
        tbl_wr.symbol     = symbol_reg;
        tbl_wr.mask       = next_states_reg;
    end

    nssu_table #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (tbl_wr),
        .rd_symbol (symbol_reg),
        .src_mask  (src_mask),
        .next_mask (step_mask)
    );

    // active set update
    always_comb begin
        active_set_next = active_set_reg;
        if (advance && (kind_reg == KIND_STEP)) begin
            active_set_next = step_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_set_reg <= '0;
        end else begin
            active_set_reg <= active_set_next;
        end
    end

    // result register
    nssu_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .set_in     (active_set_next),
        .final_mask (final_mask_reg),
        .can_load   (out_can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/nssu_table.sv
// transition table held as one lane per state, each lane a small row store per symbol
// depends on nssu_pkg; ORs the rows of all source states for one symbol
`default_nettype none

module nssu_table
    import nssu_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tbl_wr_t             wr,
    input  wire logic [SYMBOL_W-1:0] rd_symbol,
    input  wire logic [MASK_W-1:0]   src_mask,
    output logic      [MASK_W-1:0]   next_mask
);

    // states and symbols that the word fields can reach
    localparam int STATES_EFF = (NUM_STATES < MASK_W) ? NUM_STATES : MASK_W;
    localparam int SYMS_EFF   = (NUM_SYMBOLS < (1 << SYMBOL_W)) ? NUM_SYMBOLS
                                                                : (1 << SYMBOL_W);
    localparam int SYM_IDX_W  = (SYMS_EFF > 1) ? $clog2(SYMS_EFF) : 1;
    localparam logic [MASK_W-1:0] STATE_MASK = {MASK_W{1'b1}} >> (MASK_W - STATES_EFF);

    logic [MASK_W-1:0] lane_row [STATES_EFF];
    logic              wr_sym_ok;
    logic              rd_sym_ok;
    logic [SYM_IDX_W-1:0] wr_idx;
    logic [SYM_IDX_W-1:0] rd_idx;

    assign wr_sym_ok = ({{(32-SYMBOL_W){1'b0}}, wr.symbol} < SYMS_EFF);
    assign rd_sym_ok = ({{(32-SYMBOL_W){1'b0}}, rd_symbol} < SYMS_EFF);
    assign wr_idx    = wr.symbol[SYM_IDX_W-1:0];
    assign rd_idx    = rd_symbol[SYM_IDX_W-1:0];

    // one lane per state: rows for each symbol, cleared at reset
    for (genvar g = 0; g < STATES_EFF; g++) begin : g_lane
        logic [MASK_W-1:0] row_reg [SYMS_EFF];
        logic              wr_hit;

        assign wr_hit = wr.en && wr_sym_ok &&
                        (wr.from_state == STATE_W'(g));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                for (int k = 0; k < SYMS_EFF; k++) begin
                    row_reg[k] <= '0;
                end
            end else if (wr_hit) begin
                row_reg[wr_idx] <= wr.mask & STATE_MASK;
            end
        end

        assign lane_row[g] = row_reg[rd_idx];
    end

    // union of the selected rows of all active source states
    always_comb begin
        next_mask = '0;
        for (int s = 0; s < STATES_EFF; s++) begin
            if (src_mask[s]) begin
                next_mask = next_mask | lane_row[s];
            end
        end
        if (!rd_sym_ok) begin
            next_mask = '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/nssu_out_stage.sv
// result register: holds one result word until the consumer takes it
// depends on nssu_pkg; derives the accepted and dead flags from the new set
`default_nettype none

module nssu_out_stage
    import nssu_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire logic [MASK_W-1:0]   set_in,
    input  wire logic [MASK_W-1:0]   final_mask,
    output logic                     can_load,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata
);

    logic                valid_reg;
    logic                valid_next;
    logic [M_DATA_W-1:0] data_reg;
    logic [M_DATA_W-1:0] data_next;

    // free when empty or when the held word leaves this cycle
    assign can_load = !valid_reg || m_tready;

    // word: set, accepted flag, dead flag, zero padding
    always_comb begin
        data_next = '0;
        data_next[MASK_W-1:0] = set_in;
        data_next[M_ACC_BIT]  = |(set_in & final_mask);
        data_next[M_DEAD_BIT] = (set_in == '0);
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire
